// ===== rtl/irqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// irqrt_pkg
// Types and constants of the interrupt redirect entry router.
// ----------------------------------------------------------------------------
`default_nettype none

package irqrt_pkg;

  typedef enum logic [1:0] {
    KIND_ADD_OVERRIDE = 2'd0,
    KIND_ADD_IO_UNIT  = 2'd1,
    KIND_MAP_IRQ      = 2'd2,
    KIND_MAP_GSI      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_MAPPED  = 2'd0,
    ST_NO_UNIT = 2'd1,
    ST_LOADED  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Entry bit positions and flag codes
  localparam int unsigned PolarityLowBit   = 13;
  localparam int unsigned TriggerLevelBit  = 15;
  localparam logic [1:0]  FlagCodeLowLevel = 2'b11;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  irq_source;
    logic [31:0] gsi;
    logic [7:0]  vector;
    logic [7:0]  dest_apic_id;
    logic [15:0] polarity_trigger_flags;
    logic [7:0]  max_redirect;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  unit_index;
    logic [31:0] resolved_gsi;
    logic [7:0]  redirect_index;
    logic [7:0]  register_index;
    logic [31:0] entry_low;
    logic [31:0] entry_high;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  source;
    logic [31:0] target_gsi;
    logic [15:0] flags;
  } ovr_ent_t;

  typedef struct packed {
    logic [31:0] first_gsi;
    logic [7:0]  max_redirect;
  } unit_ent_t;

  // Result of the shared range compare unit
  typedef struct packed {
    logic       in_range;
    logic [7:0] diff_lo;
  } cmp_res_t;

  // Pack the low word of an unmasked, fixed, physical redirection entry
  function automatic logic [31:0] entry_low_pack(logic [7:0] vector, logic [15:0] flags);
    logic [31:0] e;
    e                  = {24'd0, vector};
    e[PolarityLowBit]  = (flags[1:0] == FlagCodeLowLevel);
    e[TriggerLevelBit] = (flags[3:2] == FlagCodeLowLevel);
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/irqrt_chan_if.sv =====
// ----------------------------------------------------------------------------
// irqrt_chan_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface irqrt_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/irqrt_ram.sv =====
// ----------------------------------------------------------------------------
// irqrt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module irqrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/irqrt_range_cmp.sv =====
// ----------------------------------------------------------------------------
// irqrt_range_cmp
// Shared compare unit: is value within [base, base + limit] without wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module irqrt_range_cmp (
  input  wire logic [31:0]        value_i,
  input  wire logic [31:0]        base_i,
  input  wire logic [7:0]         limit_i,
  output irqrt_pkg::cmp_res_t     res_o
);
  import irqrt_pkg::*;

  logic [32:0] diff;

  // Borrow out of the subtract means value is below base
  assign diff           = {1'b0, value_i} - {1'b0, base_i};
  assign res_o.in_range = !diff[32] && (diff[31:8] == 24'd0) && (diff[7:0] <= limit_i);
  assign res_o.diff_lo  = diff[7:0];

endmodule

`default_nettype wire

// ===== rtl/irq_to_redirect_entry_router.sv =====
// ----------------------------------------------------------------------------
// irq_to_redirect_entry_router
// Interrupt routing engine: stores source overrides and I/O interrupt units,
// and maps legacy irqs or gsis to redirection table entries.
// ----------------------------------------------------------------------------
// One item is worked at a time; req_i.ready is high only while the sequencer
// idles. A load (kind 0 or 1) appends to its table; a gsi map scans the unit
// table, an irq map the override table and then the unit table; a scan stops
// at the first hit. Scans are paced by the single range compare unit, which
// checks one stored entry per cycle as the table RAMs stream out one entry
// per cycle. The result sits in an output register: the sequencer can accept
// the next item while it waits, and only holds at the end of a map or load
// until the register is free. Table contents are undefined until loaded; only
// entries below the fill counts are ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module irq_to_redirect_entry_router #(
  parameter int unsigned OVERRIDE_SLOTS = 16,
  parameter int unsigned IO_UNIT_SLOTS  = 16,
  parameter int unsigned REDIRECT_BASE  = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  irqrt_chan_if.sink   req_i,
  irqrt_chan_if.source rsp_o
);
  import irqrt_pkg::*;

  // Address, count and shared scan index widths
  localparam int unsigned OAW = (OVERRIDE_SLOTS > 1) ? $clog2(OVERRIDE_SLOTS) : 1;
  localparam int unsigned UAW = (IO_UNIT_SLOTS > 1) ? $clog2(IO_UNIT_SLOTS) : 1;
  localparam int unsigned OCW = $clog2(OVERRIDE_SLOTS + 1);
  localparam int unsigned UCW = $clog2(IO_UNIT_SLOTS + 1);
  localparam int unsigned IW  = (OCW > UCW) ? OCW : UCW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OVR  = 4'b0010,
    S_UNIT = 4'b0100,
    S_LOAD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  req_t req_q, req_d;                     // accepted item
  logic [31:0] res_gsi_q, res_gsi_d;      // gsi after override lookup
  logic [15:0] res_flags_q, res_flags_d;  // flags after override lookup

  logic [OCW-1:0] ovr_cnt_q, ovr_cnt_d;
  logic [UCW-1:0] unit_cnt_q, unit_cnt_d;

  // Scan pointer: idx_q is the next entry to read, cmp_idx_q the entry whose
  // data the RAM shows now, valid when cmp_vld_q.
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          cmp_vld_q, cmp_vld_d;

  logic out_vld_q, out_vld_d;
  rsp_t rsp_q, rsp_d;

  // Table RAM ports
  logic      ovr_we, ovr_re;
  logic      unit_we, unit_re;
  ovr_ent_t  ovr_wdata, ovr_rdata;
  unit_ent_t unit_wdata, unit_rdata;

  // Shared compare unit
  logic [31:0] cmp_value, cmp_base;
  logic [7:0]  cmp_limit;
  cmp_res_t    cmp_res;

  logic out_free, ovr_full, unit_full, ovr_more, unit_more, hit;

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = rsp_q;

  assign out_free  = !out_vld_q || rsp_o.ready;
  assign ovr_full  = (ovr_cnt_q == OCW'(OVERRIDE_SLOTS));
  assign unit_full = (unit_cnt_q == UCW'(IO_UNIT_SLOTS));
  assign ovr_more  = (idx_q < IW'(ovr_cnt_q));
  assign unit_more = (idx_q < IW'(unit_cnt_q));
  assign hit       = cmp_vld_q && cmp_res.in_range;

  irqrt_ram #(
    .WIDTH ($bits(ovr_ent_t)),
    .DEPTH (OVERRIDE_SLOTS)
  ) u_ovr_ram (
    .clk_i   (clk_i),
    .we_i    (ovr_we),
    .waddr_i (ovr_cnt_q[OAW-1:0]),
    .wdata_i (ovr_wdata),
    .re_i    (ovr_re),
    .raddr_i (idx_q[OAW-1:0]),
    .rdata_o (ovr_rdata)
  );

  irqrt_ram #(
    .WIDTH ($bits(unit_ent_t)),
    .DEPTH (IO_UNIT_SLOTS)
  ) u_unit_ram (
    .clk_i   (clk_i),
    .we_i    (unit_we),
    .waddr_i (unit_cnt_q[UAW-1:0]),
    .wdata_i (unit_wdata),
    .re_i    (unit_re),
    .raddr_i (idx_q[UAW-1:0]),
    .rdata_o (unit_rdata)
  );

  assign ovr_wdata.source     = req_q.irq_source;
  assign ovr_wdata.target_gsi = req_q.gsi;
  assign ovr_wdata.flags      = req_q.polarity_trigger_flags;
  assign unit_wdata.first_gsi    = req_q.gsi;
  assign unit_wdata.max_redirect = req_q.max_redirect;

  // Override match is a range check with zero limit on the source numbers
  always_comb begin
    if (state_q == S_OVR) begin
      cmp_value = {24'd0, req_q.irq_source};
      cmp_base  = {24'd0, ovr_rdata.source};
      cmp_limit = 8'd0;
    end else begin
      cmp_value = res_gsi_q;
      cmp_base  = unit_rdata.first_gsi;
      cmp_limit = unit_rdata.max_redirect;
    end
  end

  irqrt_range_cmp u_cmp (
    .value_i (cmp_value),
    .base_i  (cmp_base),
    .limit_i (cmp_limit),
    .res_o   (cmp_res)
  );

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_gsi_d   = res_gsi_q;
    res_flags_d = res_flags_q;
    ovr_cnt_d   = ovr_cnt_q;
    unit_cnt_d  = unit_cnt_q;
    idx_d       = idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = cmp_vld_q;
    rsp_d       = rsp_q;
    out_vld_d   = out_vld_q && !rsp_o.ready;
    ovr_we      = 1'b0;
    ovr_re      = 1'b0;
    unit_we     = 1'b0;
    unit_re     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d       = req_i.data;
          res_gsi_d   = req_i.data.gsi;
          res_flags_d = req_i.data.polarity_trigger_flags;
          idx_d       = '0;
          cmp_vld_d   = 1'b0;
          case (req_i.data.kind)
            KIND_MAP_IRQ: state_d = S_OVR;
            KIND_MAP_GSI: state_d = S_UNIT;
            default:      state_d = S_LOAD;
          endcase
        end
      end

      S_LOAD: begin
        // Append to the selected table, or drop the item when it is full
        if (out_free) begin
          rsp_d        = '0;
          rsp_d.status = ST_LOADED;
          if (req_q.kind == KIND_ADD_OVERRIDE) begin
            if (ovr_full) begin
              rsp_d.status = ST_FULL;
            end else begin
              ovr_we    = 1'b1;
              ovr_cnt_d = ovr_cnt_q + 1'b1;
            end
          end else begin
            if (unit_full) begin
              rsp_d.status = ST_FULL;
            end else begin
              unit_we    = 1'b1;
              unit_cnt_d = unit_cnt_q + 1'b1;
            end
          end
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_OVR: begin
        if (hit || !ovr_more) begin
          // First matching override wins; with none, gsi is the irq itself
          if (hit) begin
            res_gsi_d   = ovr_rdata.target_gsi;
            res_flags_d = ovr_rdata.flags;
          end else begin
            res_gsi_d   = {24'd0, req_q.irq_source};
            res_flags_d = '0;
          end
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          state_d   = S_UNIT;
        end else begin
          ovr_re    = 1'b1;
          cmp_idx_d = idx_q;
          cmp_vld_d = 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end

      S_UNIT: begin
        if (hit || !unit_more) begin
          // Hold the scan until the output register is free
          if (out_free) begin
            rsp_d              = '0;
            rsp_d.resolved_gsi = res_gsi_q;
            if (hit) begin
              rsp_d.status         = ST_MAPPED;
              rsp_d.unit_index     = 4'(cmp_idx_q);
              rsp_d.redirect_index = cmp_res.diff_lo;
              rsp_d.register_index = 8'(REDIRECT_BASE) + {cmp_res.diff_lo[6:0], 1'b0};
              rsp_d.entry_low      = entry_low_pack(req_q.vector, res_flags_q);
              rsp_d.entry_high     = {req_q.dest_apic_id, 24'd0};
            end else begin
              rsp_d.status = ST_NO_UNIT;
            end
            out_vld_d = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          unit_re   = 1'b1;
          cmp_idx_d = idx_q;
          cmp_vld_d = 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ovr_cnt_q  <= '0;
      unit_cnt_q <= '0;
      idx_q      <= '0;
      cmp_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ovr_cnt_q  <= ovr_cnt_d;
      unit_cnt_q <= unit_cnt_d;
      idx_q      <= idx_d;
      cmp_vld_q  <= cmp_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    res_gsi_q   <= res_gsi_d;
    res_flags_q <= res_flags_d;
    cmp_idx_q   <= cmp_idx_d;
    rsp_q       <= rsp_d;
  end

endmodule

`default_nettype wire
